>>> src/assert_macros.svh
// Assertion macros used by the checker file of the sorted key table.
// Include with the bare file name; each macro expands to one labeled assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SKT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table assertion failed");

// next-cycle implication, off during reset
`define SKT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table assertion failed");

// next-cycle implication, always checked
`define SKT_ASSERT_NXT_ALL(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sorted_key_table assertion failed");

`endif

>>> src/skt_pkg.sv
// Package of the sorted key table: field widths, codes, types and defaults.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int TOTAL_W  = 8;
  localparam int CAP_W    = 8;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 8'd100;
  localparam logic [PADDR_W-1:0] REG_CAPACITY   = 2'd0;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FOUND     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_FINISH
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     position;
    logic [TOTAL_W-1:0]   entry_total;
  } result_t;

endpackage

`default_nettype wire

>>> src/skt_mem.sv
// Key store of the sorted key table: one write port, one read port,
// read data registered. Uses skt_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module skt_mem #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]     waddr,
  input  wire logic [skt_pkg::KEY_W-1:0]          wdata,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]     raddr,
  output logic      [skt_pkg::KEY_W-1:0]          rdata
);

  logic [skt_pkg::KEY_W-1:0] store [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

`default_nettype wire

>>> src/skt_cfg.sv
// Configuration register of the sorted key table (capacity limit) on an
// APB-style port. Uses skt_pkg for the address map and reset value.
`timescale 1ns / 1ps
`default_nettype none

module skt_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [skt_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [skt_pkg::PDATA_W-1:0]   pwdata,
  output logic      [skt_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output logic      [skt_pkg::CAP_W-1:0]     capacity
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= skt_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr == skt_pkg::REG_CAPACITY)) begin
      capacity <= pwdata[skt_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == skt_pkg::REG_CAPACITY) begin
      prdata = skt_pkg::PDATA_W'(capacity);
    end
  end

endmodule

`default_nettype wire

>>> src/skt_ctrl.sv
// Sequencer of the sorted key table: binary search over the key store, then
// an insert or delete shift through the store's single read and write ports.
// Uses skt_pkg for codes, the state type and the result word.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [skt_pkg::OP_W-1:0]         operation,
  input  wire logic [skt_pkg::KEY_W-1:0]        key,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output skt_pkg::result_t                      res,
  input  wire logic [skt_pkg::CAP_W-1:0]        capacity,
  output logic                                  mem_we,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   mem_waddr,
  output logic      [skt_pkg::KEY_W-1:0]        mem_wdata,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   mem_raddr,
  input  wire logic [skt_pkg::KEY_W-1:0]        mem_rdata
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > skt_pkg::CAP_W) ? CW : skt_pkg::CAP_W;

  skt_pkg::state_t  state, state_next;
  skt_pkg::status_t res_status;

  logic [skt_pkg::OP_W-1:0]  op_r;
  logic [skt_pkg::KEY_W-1:0] key_r;
  logic [CW-1:0]             count;
  logic [CW-1:0]             lo, hi, mid, sh;
  logic [CW-1:0]             mid_c, sh_dec;
  logic [CW-1:0]             res_pos;
  logic                      hit;
  logic                      wp;
  logic [AW-1:0]             wa;
  logic                      full;
  logic                      out_free;

  assign mid_c    = lo + ((hi - lo) >> 1);
  assign sh_dec   = sh - CW'(1);
  assign full     = (CMPW'(count) >= CMPW'(capacity)) || (count == CW'(TABLE_DEPTH));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == skt_pkg::S_IDLE);

  // write port: pending shift word, else the new key
  assign mem_we    = wp || (state == skt_pkg::S_PUT);
  assign mem_waddr = wp ? wa : lo[AW-1:0];
  assign mem_wdata = wp ? mem_rdata : key_r;

  always_comb begin
    case (state)
      skt_pkg::S_SHIFT_UP: mem_raddr = sh_dec[AW-1:0];
      skt_pkg::S_SHIFT_DN: mem_raddr = sh[AW-1:0];
      default:             mem_raddr = mid_c[AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      skt_pkg::S_IDLE: begin
        if (in_valid) state_next = skt_pkg::S_SRCH_RD;
      end
      skt_pkg::S_SRCH_RD: begin
        state_next = (lo < hi) ? skt_pkg::S_SRCH_CMP : skt_pkg::S_DECIDE;
      end
      skt_pkg::S_SRCH_CMP: state_next = skt_pkg::S_SRCH_RD;
      skt_pkg::S_DECIDE: begin
        if ((op_r == skt_pkg::OP_INSERT) && !full && !hit) begin
          state_next = skt_pkg::S_SHIFT_UP;
        end else if ((op_r == skt_pkg::OP_DELETE) && hit) begin
          state_next = skt_pkg::S_SHIFT_DN;
        end else begin
          state_next = skt_pkg::S_FINISH;
        end
      end
      skt_pkg::S_SHIFT_UP: begin
        if (sh <= lo) state_next = skt_pkg::S_PUT;
      end
      skt_pkg::S_PUT: state_next = skt_pkg::S_FINISH;
      skt_pkg::S_SHIFT_DN: begin
        if (sh >= count) state_next = skt_pkg::S_FINISH;
      end
      skt_pkg::S_FINISH: begin
        if (out_free) state_next = skt_pkg::S_IDLE;
      end
      default: state_next = skt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skt_pkg::S_IDLE;
    end else begin
      state     <= state_next;
    end
  end

  // a shift step reads now and writes the word back in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
    end else begin
      wp <= ((state == skt_pkg::S_SHIFT_UP) && (sh > lo)) ||
            ((state == skt_pkg::S_SHIFT_DN) && (sh < count));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == skt_pkg::S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
    end else begin
      case (state)
        skt_pkg::S_IDLE: begin
          if (in_valid) begin
            op_r  <= operation;
            key_r <= key;
            lo    <= '0;
            hi    <= count;
            hit   <= 1'b0;
          end
        end
        skt_pkg::S_SRCH_RD: mid <= mid_c;
        skt_pkg::S_SRCH_CMP: begin
          if ($signed(mem_rdata) < $signed(key_r)) begin
            lo <= mid + CW'(1);
          end else begin
            hi  <= mid;
            hit <= (mem_rdata == key_r);
          end
        end
        skt_pkg::S_DECIDE: begin
          case (op_r)
            skt_pkg::OP_INSERT: begin
              if (full) begin
                res_status <= skt_pkg::ST_FULL;
                res_pos    <= '0;
              end else if (hit) begin
                res_status <= skt_pkg::ST_DUPLICATE;
                res_pos    <= '0;
              end else begin
                res_status <= skt_pkg::ST_INSERTED;
                res_pos    <= lo;
                sh         <= count;
              end
            end
            skt_pkg::OP_DELETE: begin
              if (hit) begin
                res_status <= skt_pkg::ST_DELETED;
                res_pos    <= lo;
                sh         <= lo + CW'(1);
              end else begin
                res_status <= skt_pkg::ST_NOT_FOUND;
                res_pos    <= '0;
              end
            end
            skt_pkg::OP_LOOKUP: begin
              if (hit) begin
                res_status <= skt_pkg::ST_FOUND;
                res_pos    <= lo;
              end else begin
                res_status <= skt_pkg::ST_NOT_FOUND;
                res_pos    <= '0;
              end
            end
            default: begin
              res_status <= skt_pkg::ST_NOT_FOUND;
              res_pos    <= '0;
            end
          endcase
        end
        skt_pkg::S_SHIFT_UP: begin
          // move entry sh-1 to sh, one per cycle, top down
          if (sh > lo) begin
            wa <= sh[AW-1:0];
            sh <= sh_dec;
          end
        end
        skt_pkg::S_PUT: count <= count + CW'(1);
        skt_pkg::S_SHIFT_DN: begin
          // move entry sh to sh-1, bottom up
          if (sh < count) begin
            wa <= sh_dec[AW-1:0];
            sh <= sh + CW'(1);
          end else begin
            count <= count - CW'(1);
          end
        end
        skt_pkg::S_FINISH: begin
          if (out_free) begin
            res.status          <= res_status;
            res.position        <= skt_pkg::POS_W'(res_pos);
            res.entry_total     <= skt_pkg::TOTAL_W'(count);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/sorted_key_table.sv
// Sorted key table: holds up to TABLE_DEPTH distinct signed 32-bit keys in
// ascending order in one single-port-read, single-port-write memory. Each
// input word (insert, delete or look up) returns one result word with status,
// sorted position and the new key count. One item is in work at a time: each
// halving step of the binary search reads the memory, then compares, and an
// insert or delete then moves one entry per cycle through the memory port.
// A new word is taken while the last result still waits in the output
// register. No clearing pass after reset.
// Depends on skt_pkg, skt_cfg, skt_ctrl and skt_mem.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [skt_pkg::OP_W-1:0]        operation,
  input  wire logic [skt_pkg::KEY_W-1:0]       key,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [skt_pkg::STATUS_W-1:0]    status,
  output logic      [skt_pkg::POS_W-1:0]       position,
  output logic      [skt_pkg::TOTAL_W-1:0]     entry_total,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [skt_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [skt_pkg::PDATA_W-1:0]     pwdata,
  output logic      [skt_pkg::PDATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  skt_pkg::result_t           res;
  logic [skt_pkg::CAP_W-1:0]  capacity;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [skt_pkg::KEY_W-1:0]  mem_wdata, mem_rdata;

  assign status      = res.status;
  assign position    = res.position;
  assign entry_total = res.entry_total;

  skt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  skt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .capacity  (capacity),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skt_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> src/skt_checker.sv
// Port-level checker of the sorted key table, bound to the top level.
// Depends on skt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module skt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [skt_pkg::STATUS_W-1:0]   status,
  input wire logic [skt_pkg::POS_W-1:0]      position,
  input wire logic [skt_pkg::TOTAL_W-1:0]    entry_total
);

  logic refused_word;

  assign refused_word = out_valid && ((status == skt_pkg::ST_NOT_FOUND) ||
                                      (status == skt_pkg::ST_DUPLICATE) ||
                                      (status == skt_pkg::ST_FULL));

  // one word in work at a time: taking a word closes the input
  `SKT_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // refused and missing keys carry no position
  `SKT_ASSERT_IMP(a_pos_zero, clk, rst, refused_word, position == '0)

  // a stalled result holds
  `SKT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(position) && $stable(entry_total))

  // reset empties the output stage
  `SKT_ASSERT_NXT_ALL(a_reset_clears, clk, rst, !out_valid && in_ready)

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

`default_nettype wire
